// ----- src/min_priority_queue_decrease_key_core_assert.svh -----
// Assertion macros used by the checker file of the priority queue core.
`ifndef MIN_PRIORITY_QUEUE_DECREASE_KEY_CORE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_DECREASE_KEY_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQDK_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPQDK_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mpqdk_pkg.sv -----
// Shared types and command codes of the priority queue core.
`default_nettype none

package mpqdk_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_EXTRACT  = 2'd1,
        CMD_PEEK     = 2'd2,
        CMD_DECREASE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CELL_HOLD    = 3'd0,
        CELL_INSERT  = 3'd1,
        CELL_SHIFT   = 3'd2,
        CELL_REPLACE = 3'd3,
        CELL_SWAP    = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/mpqdk_cell.sv -----
// One storage cell of the sorted token row.
`default_nettype none

module mpqdk_cell
    import mpqdk_pkg::*;
#(
    parameter int TOKEN_BITS = 16,
    parameter bit PARITY     = 1'b0
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [TOKEN_BITS-1:0] tok,
    input  wire logic [TOKEN_BITS-1:0] ntok,
    input  wire logic [TOKEN_BITS-1:0] left_val,
    input  wire logic                  left_vld,
    input  wire logic                  left_gt,
    input  wire logic                  left_inv,
    input  wire logic [TOKEN_BITS-1:0] right_val,
    input  wire logic                  right_vld,
    output logic [TOKEN_BITS-1:0]      val,
    output logic                       vld,
    output logic                       gt,
    output logic                       inv
);

    logic [TOKEN_BITS-1:0] val_reg;
    logic [TOKEN_BITS-1:0] val_next;
    logic                  vld_reg;
    logic                  vld_next;

    assign val = val_reg;
    assign vld = vld_reg;
    assign gt  = !vld_reg || (val_reg > tok);
    assign inv = vld_reg && right_vld && (val_reg > right_val);

    always_comb begin
        val_next = val_reg;
        vld_next = vld_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (left_gt) begin
                    val_next = left_val;
                end else if (gt) begin
                    val_next = tok;
                end
                vld_next = vld_reg || left_vld;
            end
            CELL_SHIFT: begin
                val_next = right_val;
                vld_next = right_vld;
            end
            CELL_REPLACE: begin
                if (vld_reg && (val_reg == tok)) begin
                    val_next = ntok;
                end
            end
            CELL_SWAP: begin
                if (PARITY == ctrl.phase) begin
                    if (inv) begin
                        val_next = right_val;
                    end
                end else if (left_inv) begin
                    val_next = left_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

// ----- src/min_priority_queue_decrease_key_core.sv -----
// Top level of the min-priority queue core: cell row, command control and output register.
`default_nettype none

// Bounded min-priority queue of DEPTH tokens held in ascending order in a row of cells,
// smallest in cell 0. Each request on s_ carries a command: insert, extract smallest, peek
// smallest or decrease a matching token; each gives exactly one result on m_. Insert and
// extract update the row at acceptance, peek leaves it as it is, and the result is then
// loaded into the output register; a new request is taken only after that load. Decrease
// with a new token below the old one rewrites every matching cell at acceptance, then runs
// odd-even compare-and-swap phases between neighbor cells until the row is ordered again;
// a decrease whose new token is not smaller leaves the row as it is. An insert into a full
// queue is dropped and flagged; extract or peek on an empty queue is flagged. A result that
// waits on m_tready holds the next request off until the output register frees.

module min_priority_queue_decrease_key_core
    import mpqdk_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int TOKEN_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // command, token, new_token
    input  wire logic [((2*TOKEN_BITS+2+7)/8)*8-1:0]    s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // result_token, queue_empty, queue_full, occupancy
    output logic [((TOKEN_BITS+9+7)/8)*8-1:0]           m_tdata
);

    localparam int M_W   = ((TOKEN_BITS+9+7)/8)*8;
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int OCC_W = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  phase_reg;
    logic [TOKEN_BITS-1:0] tok_reg;
    logic [TOKEN_BITS-1:0] res_reg;
    logic                  empty_reg;
    logic                  full_reg;
    logic                  m_tvalid_reg;
    logic [TOKEN_BITS-1:0] out_tok_reg;
    logic                  out_empty_reg;
    logic                  out_full_reg;
    logic [OCC_W-1:0]      out_occ_reg;

    cmd_t                  cmd;
    logic [TOKEN_BITS-1:0] in_tok;
    logic [TOKEN_BITS-1:0] in_ntok;
    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic                  sorted;
    logic                  out_free;
    cell_ctrl_t            ctrl;
    logic [TOKEN_BITS-1:0] cell_tok;
    logic [CNT_W+OCC_W-1:0] count_ext;

    logic [TOKEN_BITS-1:0] val_arr [DEPTH];
    logic [DEPTH-1:0]      vld_vec;
    logic [DEPTH-1:0]      gt_vec;
    logic [DEPTH-1:0]      inv_vec;

    assign cmd      = cmd_t'(s_tdata[1:0]);
    assign in_tok   = s_tdata[2 +: TOKEN_BITS];
    assign in_ntok  = s_tdata[2+TOKEN_BITS +: TOKEN_BITS];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign sorted   = ~|inv_vec;
    assign out_free = !m_tvalid_reg || m_tready;
    assign count_ext = {{OCC_W{1'b0}}, count_reg};

    // Insert and replace use the live request token at acceptance; otherwise the registered one.
    assign cell_tok = accept ? in_tok : tok_reg;

    always_comb begin
        ctrl.op    = CELL_HOLD;
        ctrl.phase = phase_reg;
        if (accept) begin
            unique case (cmd)
                CMD_INSERT:   ctrl.op = is_full ? CELL_HOLD : CELL_INSERT;
                CMD_EXTRACT:  ctrl.op = is_empty ? CELL_HOLD : CELL_SHIFT;
                CMD_PEEK:     ctrl.op = CELL_HOLD;
                CMD_DECREASE: ctrl.op = (in_ntok < in_tok) ? CELL_REPLACE : CELL_HOLD;
                default:      ctrl.op = CELL_HOLD;
            endcase
        end else if ((state_reg == ST_SETTLE) && !sorted) begin
            ctrl.op = CELL_SWAP;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.op == CELL_INSERT) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.op == CELL_SHIFT) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [TOKEN_BITS-1:0] l_val;
        logic                  l_vld;
        logic                  l_gt;
        logic                  l_inv;
        logic [TOKEN_BITS-1:0] r_val;
        logic                  r_vld;

        if (i == 0) begin : g_first
            assign l_val = '0;
            assign l_vld = 1'b1;
            assign l_gt  = 1'b0;
            assign l_inv = 1'b0;
        end else begin : g_mid_l
            assign l_val = val_arr[i-1];
            assign l_vld = vld_vec[i-1];
            assign l_gt  = gt_vec[i-1];
            assign l_inv = inv_vec[i-1];
        end

        if (i == DEPTH-1) begin : g_last
            assign r_val = '0;
            assign r_vld = 1'b0;
        end else begin : g_mid_r
            assign r_val = val_arr[i+1];
            assign r_vld = vld_vec[i+1];
        end

        mpqdk_cell #(
            .TOKEN_BITS (TOKEN_BITS),
            .PARITY     (1'(i % 2))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .tok       (cell_tok),
            .ntok      (in_ntok),
            .left_val  (l_val),
            .left_vld  (l_vld),
            .left_gt   (l_gt),
            .left_inv  (l_inv),
            .right_val (r_val),
            .right_vld (r_vld),
            .val       (val_arr[i]),
            .vld       (vld_vec[i]),
            .gt        (gt_vec[i]),
            .inv       (inv_vec[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            phase_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        phase_reg <= 1'b0;
                        if (ctrl.op == CELL_REPLACE) begin
                            state_reg <= ST_SETTLE;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_SETTLE: begin
                    if (sorted) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        phase_reg <= !phase_reg;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Hold the request fields and the pending result; load the output register on emit.
    always_ff @(posedge aclk) begin
        if (accept) begin
            tok_reg   <= in_tok;
            res_reg   <= '0;
            empty_reg <= 1'b0;
            full_reg  <= 1'b0;
            if ((cmd == CMD_EXTRACT) || (cmd == CMD_PEEK)) begin
                if (is_empty) begin
                    empty_reg <= 1'b1;
                end else begin
                    res_reg <= val_arr[0];
                end
            end else if ((cmd == CMD_INSERT) && is_full) begin
                full_reg <= 1'b1;
            end
        end
        if ((state_reg == ST_EMIT) && out_free) begin
            out_tok_reg   <= res_reg;
            out_empty_reg <= empty_reg;
            out_full_reg  <= full_reg;
            out_occ_reg   <= count_ext[OCC_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_W'({out_occ_reg, out_full_reg, out_empty_reg, out_tok_reg});

endmodule

`default_nettype wire

// ----- src/mpqdk_checker.sv -----
// Port-level checker for the priority queue core and its bind.
`default_nettype none

`include "min_priority_queue_decrease_key_core_assert.svh"

module mpqdk_checker #(
    parameter int TOKEN_BITS = 16
) (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [((TOKEN_BITS+9+7)/8)*8-1:0]   m_tdata
);

    localparam int EMPTY_BIT = TOKEN_BITS;
    localparam int FULL_BIT  = TOKEN_BITS + 1;

    logic                  s_fire;
    logic [TOKEN_BITS-1:0] res_tok;
    logic                  res_empty;
    logic                  res_full;

    assign s_fire    = s_tvalid && s_tready;
    assign res_tok   = m_tdata[TOKEN_BITS-1:0];
    assign res_empty = m_tdata[EMPTY_BIT];
    assign res_full  = m_tdata[FULL_BIT];

    `MPQDK_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")

    `MPQDK_ASSERT_NXT(a_busy_after_req, aclk, aresetn, s_fire,
        !s_tready, "request taken on consecutive cycles")

    `MPQDK_ASSERT_IMP(a_flags_exclusive, aclk, aresetn, m_tvalid,
        !(res_empty && res_full), "empty and full flagged together")

    `MPQDK_ASSERT_IMP(a_flag_zero_token, aclk, aresetn, m_tvalid && (res_empty || res_full),
        res_tok == '0, "flagged result carries a token")

endmodule

bind min_priority_queue_decrease_key_core mpqdk_checker #(
    .TOKEN_BITS (TOKEN_BITS)
) u_mpqdk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/min_priority_queue_decrease_key_core_tb.sv -----
// Self-checking testbench for the min-priority queue core with decrease-key.
`default_nettype none

module min_priority_queue_decrease_key_core_tb;
    import mpqdk_pkg::*;

    localparam int DEPTH         = 64;
    localparam int TOKEN_BITS    = 16;
    localparam int S_BITS        = ((2*TOKEN_BITS+2+7)/8)*8;
    localparam int M_BITS        = ((TOKEN_BITS+9+7)/8)*8;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = DEPTH + 40;
    localparam int LONG_HOLD     = 300;
    localparam int PRINT_LIMIT   = 40;

    typedef struct {
        cmd_t        command;
        logic [15:0] token;
        logic [15:0] new_token;
    } pq_request_t;

    typedef struct {
        logic [15:0] result_token;
        logic        queue_empty;
        logic        queue_full;
        logic [6:0]  occupancy;
    } pq_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_BITS-1:0] m_tdata;

    pq_request_t pending_requests[$];
    pq_result_t  expected_results[$];
    pq_request_t active_request;

    logic [15:0] held_tokens[DEPTH];
    int          held_count = 0;
    logic [15:0] token_pool[6];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_req           = 1'b0;
    bit hold_done;
    int hold_cnt;
    int fail_count         = 0;
    int stall_cycles       = 0;

    min_priority_queue_decrease_key_core #(
        .DEPTH      (DEPTH),
        .TOKEN_BITS (TOKEN_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic pq_result_t predict_queue(pq_request_t req);
        pq_result_t  res;
        int          pos;
        int          j;
        logic [15:0] v;
        res = '{16'd0, 1'b0, 1'b0, 7'd0};
        case (req.command)
            CMD_INSERT: begin
                if (held_count >= DEPTH) begin
                    res.queue_full = 1'b1;
                end else begin
                    pos = held_count;
                    while (pos > 0 && held_tokens[pos-1] > req.token) begin
                        held_tokens[pos] = held_tokens[pos-1];
                        pos--;
                    end
                    held_tokens[pos] = req.token;
                    held_count++;
                end
            end
            CMD_EXTRACT, CMD_PEEK: begin
                if (held_count == 0) begin
                    res.queue_empty = 1'b1;
                end else begin
                    res.result_token = held_tokens[0];
                    if (req.command == CMD_EXTRACT) begin
                        for (int i = 0; i + 1 < held_count; i++)
                            held_tokens[i] = held_tokens[i+1];
                        held_count--;
                    end
                end
            end
            default: begin
                if (req.new_token < req.token) begin
                    for (int i = 0; i < held_count; i++)
                        if (held_tokens[i] == req.token)
                            held_tokens[i] = req.new_token;
                    for (int i = 1; i < held_count; i++) begin
                        v = held_tokens[i];
                        j = i;
                        while (j > 0 && held_tokens[j-1] > v) begin
                            held_tokens[j] = held_tokens[j-1];
                            j--;
                        end
                        held_tokens[j] = v;
                    end
                end
            end
        endcase
        res.occupancy = held_count[6:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned exp_value,
                                   int unsigned act_value);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s expected 0x%0h got 0x%0h",
                     $realtime, what, exp_value, act_value);
        fail_count++;
    endtask

    task automatic add_request(cmd_t command, logic [15:0] token, logic [15:0] new_token);
        pq_request_t req;
        req.command   = command;
        req.token     = token;
        req.new_token = new_token;
        pending_requests.push_back(req);
    endtask

    task automatic add_episode(int count, int insert_pct, int extract_pct, int peek_pct);
        bit          narrow;
        int          r;
        logic [15:0] tok;
        logic [15:0] ntok;
        narrow = $urandom_range(0, 1);
        foreach (token_pool[i])
            token_pool[i] = narrow ? 16'($urandom_range(0, 15)) : 16'($urandom_range(0, 65535));
        for (int k = 0; k < count; k++) begin
            r    = $urandom_range(0, 99);
            tok  = ($urandom_range(0, 3) != 0) ? token_pool[$urandom_range(0, 5)]
                                               : 16'($urandom_range(0, 65535));
            ntok = 16'($urandom_range(0, 65535));
            if (r < insert_pct) begin
                add_request(CMD_INSERT, tok, ntok);
            end else if (r < insert_pct + extract_pct) begin
                add_request(CMD_EXTRACT, tok, ntok);
            end else if (r < insert_pct + extract_pct + peek_pct) begin
                add_request(CMD_PEEK, tok, ntok);
            end else begin
                if (tok != 0 && $urandom_range(0, 3) != 0)
                    ntok = 16'($urandom_range(0, tok - 1));
                add_request(CMD_DECREASE, tok, ntok);
            end
        end
    endtask

    // driver: hold the offered request until accepted, predict on acceptance
    always @(posedge aclk) begin : drive_requests
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_queue(active_request));
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    active_request = pending_requests.pop_front();
                    s_tdata  <= {{(S_BITS-34){1'b0}}, active_request.new_token,
                                 active_request.token, active_request.command};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == LONG_HOLD - 1)
                hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        pq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 0, m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[15:0] !== want.result_token)
                    report_mismatch("result_token", want.result_token, m_tdata[15:0]);
                if (m_tdata[16] !== want.queue_empty)
                    report_mismatch("queue_empty", want.queue_empty, m_tdata[16]);
                if (m_tdata[17] !== want.queue_full)
                    report_mismatch("queue_full", want.queue_full, m_tdata[17]);
                if (m_tdata[24:18] !== want.occupancy)
                    report_mismatch("occupancy", want.occupancy, m_tdata[24:18]);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_request(CMD_PEEK,     16'h0000, 16'hFFFF);
        add_request(CMD_EXTRACT,  16'hFFFF, 16'h0000);
        add_request(CMD_DECREASE, 16'd5,    16'd1);
        add_request(CMD_INSERT,   16'hFFFF, 16'h0000);
        add_request(CMD_INSERT,   16'h0000, 16'hFFFF);
        add_request(CMD_INSERT,   16'd100,  16'd0);
        add_request(CMD_INSERT,   16'd100,  16'd0);
        add_request(CMD_INSERT,   16'd100,  16'd0);
        add_request(CMD_PEEK,     16'd0,    16'd0);
        add_request(CMD_DECREASE, 16'd100,  16'd50);
        add_request(CMD_DECREASE, 16'd50,   16'd50);
        add_request(CMD_DECREASE, 16'd50,   16'd60);
        add_request(CMD_DECREASE, 16'd7,    16'd3);
        add_request(CMD_DECREASE, 16'hFFFF, 16'h0000);
        add_request(CMD_PEEK,     16'd0,    16'd0);
        for (int i = 0; i < 6; i++)
            add_request(CMD_EXTRACT, 16'd0, 16'd0);
        add_request(CMD_INSERT,   16'h5555, 16'hAAAA);
        add_request(CMD_INSERT,   16'hAAAA, 16'h5555);
        add_request(CMD_EXTRACT,  16'h0000, 16'h0000);
        add_request(CMD_PEEK,     16'h0000, 16'h0000);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
                default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
            endcase
            add_episode(95, 85, 5, 5);
            if (phase == 0)
                hold_req = 1'b1;
            add_episode(90, 5, 80, 5);
            while (pending_requests.size() != 0)
                @(negedge aclk);
        end

        while (s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("missing results", 0, expected_results.size());
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
